FILE: rtl/dstg_pkg.sv
`timescale 1ns / 1ps
// Package for the decaying sine tone generator: field widths, register indexes,
// sine polynomial constants and the function that builds the sine table. No dependencies.
package dstg_pkg;

  localparam int SINE_TABLE_DEPTH_DEF = 1024;
  localparam int PHASE_BITS_DEF       = 32;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int SAMPLE_W    = 16;
  localparam int COUNT_W     = 16;
  localparam int ENV_W       = 32;
  localparam int GAIN_W      = 15;
  localparam int MAG_W       = 15;

  localparam logic [CFG_INDEX_W-1:0] REG_PHASE_STEP    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_COUNT  = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_ENVELOPE_STEP = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_VOLUME_GAIN   = 2'd3;

  localparam logic [ENV_W-1:0] ENV_FULL = 32'hFFFF_FFFF;

  // Q30 odd polynomial coefficients for sin(pi/2 * x)
  localparam logic [63:0] C1      = 64'd1686629713;
  localparam logic [63:0] C3      = 64'd693598668;
  localparam logic [63:0] C5      = 64'd85569305;
  localparam logic [63:0] C7      = 64'd5026995;
  localparam logic [63:0] C9      = 64'd172272;
  localparam logic [63:0] Q30_ONE = 64'd1073741824;
  localparam logic [63:0] MAG_MAX = 64'd32767;
  localparam logic [63:0] RND_15  = 64'd16384;

  // p is the table phase in 2^32 units per turn; evaluated at elaboration only.
  function automatic logic signed [SAMPLE_W-1:0] sine_of_phase(input logic [63:0] p);
    logic [1:0]  quad;
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    logic [63:0] mag;
    quad = p[31:30];
    x = {34'd0, p[29:0]};
    if (quad[0]) begin
      x = Q30_ONE - x;
    end
    x2 = (x * x) >> 30;
    t = C9;
    t = C7 - ((x2 * t) >> 30);
    t = C5 - ((x2 * t) >> 30);
    t = C3 - ((x2 * t) >> 30);
    t = C1 - ((x2 * t) >> 30);
    s = (x * t) >> 30;
    if (s > Q30_ONE) begin
      s = Q30_ONE;
    end
    mag = (s + RND_15) >> 15;
    if (mag > MAG_MAX) begin
      mag = MAG_MAX;
    end
    return quad[1] ? -SAMPLE_W'(mag) : SAMPLE_W'(mag);
  endfunction

endpackage

FILE: rtl/dstg_if.sv
`timescale 1ns / 1ps
// Channel interfaces of the decaying sine tone generator: request, result and
// register write. Depends on dstg_pkg for field widths.
interface dstg_req_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface

interface dstg_rsp_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [dstg_pkg::SAMPLE_W-1:0]  sample_out;
  logic                                  active;
  logic                                  last;
  modport source (output valid, output sample_out, output active, output last, input ready);
  modport sink   (input valid, input sample_out, input active, input last, output ready);
endinterface

interface dstg_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [dstg_pkg::CFG_INDEX_W-1:0]    index;
  logic [dstg_pkg::CFG_DATA_W-1:0]     data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/dstg_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dstg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic                                     re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/decaying_sine_tone_generator_top.sv
`timescale 1ns / 1ps
// Decaying sine tone generator top level: state RAM, sine table, envelope and gain.
// Depends on dstg_pkg, dstg_if (interfaces) and dstg_ram.
//
// Usage:
//   req  : one request per audio sample; restart=1 starts the tone over at sample zero.
//   rsp  : one result per request: sample_out (signed), active, last.
//   cfg  : register writes (index 0 phase_step, 1 sample_count, 2 envelope_step,
//          3 volume_gain); always ready, write only while no request is in flight.
// Oscillator state (phase, sample index, envelope, active flag) lives in a one-word
// RAM that is read on request accept and, while the tone is active, written back in
// the cycle after; a valid flag makes the never-written word read as all zero, so no
// clearing pass is needed. Each sample passes the serial chain state read -> table
// address multiply -> sine ROM read -> gain multiply -> envelope multiply -> output
// register, and no new request is taken until the result reaches the output register.
// The output register holds a result while the receiver stalls; the block already
// accepts the next request, and it waits at the final step until the register frees.
// Reset (synchronous, rst high) idles the tone and clears the control state, the
// output valid flag, the state RAM valid flag and the configuration registers
// (sample_count to 1).
module decaying_sine_tone_generator_top #(
  parameter int SINE_TABLE_DEPTH = dstg_pkg::SINE_TABLE_DEPTH_DEF,
  parameter int PHASE_BITS       = dstg_pkg::PHASE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  dstg_req_if.sink    req,
  dstg_rsp_if.source  rsp,
  dstg_cfg_if.sink    cfg
);

  localparam int ADDR_W  = $clog2(SINE_TABLE_DEPTH);
  localparam int DMUL_W  = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PROD_W  = PHASE_BITS + DMUL_W;
  localparam int ST_W    = 1 + dstg_pkg::COUNT_W + dstg_pkg::ENV_W + PHASE_BITS;
  localparam int GM_W    = 2 * dstg_pkg::MAG_W;
  localparam int EM_W    = GM_W + dstg_pkg::ENV_W;

  typedef enum logic [2:0] {
    S_IDLE, S_CALC, S_SINE, S_MUL1, S_MUL2, S_OUT
  } state_t;

  // ---------------- configuration registers ----------------
  logic [PHASE_BITS-1:0]           phase_step;
  logic [dstg_pkg::COUNT_W-1:0]    sample_count;
  logic [dstg_pkg::ENV_W-1:0]      envelope_step;
  logic [dstg_pkg::GAIN_W-1:0]     volume_gain;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step    <= '0;
      sample_count  <= dstg_pkg::COUNT_W'(1);
      envelope_step <= '0;
      volume_gain   <= '0;
    end else if (cfg.valid) begin
      case (cfg.index)
        dstg_pkg::REG_PHASE_STEP:    phase_step    <= cfg.data[PHASE_BITS-1:0];
        dstg_pkg::REG_SAMPLE_COUNT:  sample_count  <= cfg.data[dstg_pkg::COUNT_W-1:0];
        dstg_pkg::REG_ENVELOPE_STEP: envelope_step <= cfg.data[dstg_pkg::ENV_W-1:0];
        dstg_pkg::REG_VOLUME_GAIN:   volume_gain   <= cfg.data[dstg_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------- sine table ----------------
  logic signed [dstg_pkg::SAMPLE_W-1:0] sine_rom [SINE_TABLE_DEPTH];

  for (genvar k = 0; k < SINE_TABLE_DEPTH; k++) begin : g_rom
    localparam logic [63:0] P = (64'(k) << 32) / SINE_TABLE_DEPTH;
    assign sine_rom[k] = dstg_pkg::sine_of_phase(P);
  end

  // ---------------- state RAM ----------------
  logic            st_re;
  logic            st_we;
  logic [ST_W-1:0] st_rdata;
  logic [ST_W-1:0] st_wdata;
  logic            st_valid;

  dstg_ram #(
    .WIDTH (ST_W),
    .DEPTH (1)
  ) u_state_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (1'b0),
    .wdata (st_wdata),
    .re    (st_re),
    .raddr (1'b0),
    .rdata (st_rdata)
  );

  state_t state;
  logic   restart_q;

  assign req.ready = (state == S_IDLE);
  assign st_re     = req.valid && req.ready;

  // ---------------- state update (S_CALC) ----------------
  logic [ST_W-1:0]              cur;
  logic [PHASE_BITS-1:0]        acc;
  logic [dstg_pkg::COUNT_W-1:0] idx;
  logic [dstg_pkg::ENV_W-1:0]   env;
  logic                         act;
  logic [dstg_pkg::COUNT_W-1:0] count_eff;
  logic                         is_last;
  logic [PROD_W-1:0]            addr_prod;
  logic [dstg_pkg::COUNT_W-1:0] idx_next;
  logic [dstg_pkg::ENV_W-1:0]   env_next;
  logic [PHASE_BITS-1:0]        acc_next;
  logic                         act_next;

  always_comb begin
    cur = st_valid ? st_rdata : '0;   // unwritten word reads as reset value
    {act, idx, env, acc} = cur;
    if (restart_q) begin
      acc = '0;
      idx = '0;
      env = dstg_pkg::ENV_FULL;
      act = 1'b1;
    end
    count_eff = (sample_count == '0) ? dstg_pkg::COUNT_W'(1) : sample_count;
    is_last   = ({1'b0, idx} + 17'd1) >= {1'b0, count_eff};
    addr_prod = PROD_W'(acc) * PROD_W'(SINE_TABLE_DEPTH);
    acc_next  = acc + phase_step;
    env_next  = (env > envelope_step) ? env - envelope_step : '0;
    idx_next  = idx + dstg_pkg::COUNT_W'(1);
    act_next  = !is_last;
    st_wdata  = {act_next, idx_next, env_next, acc_next};
  end

  assign st_we = (state == S_CALC) && act;

  // ---------------- datapath and control ----------------
  logic [ADDR_W-1:0]                    addr_q;
  logic [dstg_pkg::ENV_W-1:0]           env_q;
  logic                                 active_q;
  logic                                 last_q;
  logic signed [dstg_pkg::SAMPLE_W-1:0] sine_q;
  logic                                 neg_q;
  logic [GM_W-1:0]                      gm_q;
  logic [dstg_pkg::MAG_W-1:0]           mag_q;
  logic [dstg_pkg::SAMPLE_W-1:0]        sine_abs;
  logic [EM_W-1:0]                      env_prod;
  logic                                 out_free;

  assign sine_abs = sine_q[dstg_pkg::SAMPLE_W-1] ? -sine_q : sine_q;
  assign env_prod = EM_W'(gm_q) * EM_W'(env_q);
  assign out_free = !rsp.valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      st_valid  <= 1'b0;
      rsp.valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        rsp.valid <= 1'b1;
      end else if (rsp.ready) begin
        rsp.valid <= 1'b0;
      end
      if (st_we) begin
        st_valid <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            restart_q <= req.restart;
            state     <= S_CALC;
          end
        end
        S_CALC: begin
          addr_q   <= addr_prod[PHASE_BITS +: ADDR_W];
          env_q    <= env;
          active_q <= act;
          last_q   <= act && is_last;
          state    <= S_SINE;
        end
        S_SINE: begin
          sine_q <= sine_rom[addr_q];
          state  <= S_MUL1;
        end
        S_MUL1: begin
          neg_q <= sine_q[dstg_pkg::SAMPLE_W-1];
          gm_q  <= GM_W'(sine_abs[dstg_pkg::MAG_W-1:0]) * GM_W'(volume_gain);
          state <= S_MUL2;
        end
        S_MUL2: begin
          mag_q <= env_prod[47 +: dstg_pkg::MAG_W];
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            rsp.active <= active_q;
            rsp.last   <= last_q;
            if (!active_q) begin
              rsp.sample_out <= '0;
            end else if (neg_q) begin
              rsp.sample_out <= -$signed({1'b0, mag_q});
            end else begin
              rsp.sample_out <= $signed({1'b0, mag_q});
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // ---------------- assertions ----------------
  // one request at a time: an accept closes the request side for the next cycle
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while another is in flight");

  // state write-back only occurs in the cycle after a state read
  a_rmw_order: assert property (@(posedge clk) disable iff (rst)
    st_we |-> $past(st_re))
    else $error("state write without preceding read");

  // a last flag never goes out on an idle result
  a_last_active: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.last |-> rsp.active)
    else $error("last set on inactive result");

endmodule
